// ===== hdl/mac_grid_wall_boundary_defines.svh =====
// Assertion macros used by the block's top module.
// Each macro expects clk and rst_n in scope.
`ifndef MAC_GRID_WALL_BOUNDARY_DEFINES_SVH
`define MAC_GRID_WALL_BOUNDARY_DEFINES_SVH

// Condition holds in the same cycle as the trigger
`define MGWB_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger
`define MGWB_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== hdl/mgwb_pkg.sv =====
package mgwb_pkg;

  // Default grid capacity per axis
  localparam int unsigned MAX_X_DEF = 32;
  localparam int unsigned MAX_Y_DEF = 32;
  localparam int unsigned MAX_Z_DEF = 32;

  // Field widths
  localparam int unsigned POS_W  = 5;
  localparam int unsigned SIZE_W = 6;
  localparam int unsigned VEL_W  = 32;
  localparam int unsigned CMP_W  = 9;   // holds any capacity up to 256
  localparam int unsigned FLAG_W = 3;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 96;
  localparam int unsigned CFG_AW     = 4;
  localparam int unsigned CFG_DW     = 32;

  // Input tdata layout
  localparam int unsigned POS_X_LSB = 0;
  localparam int unsigned POS_Y_LSB = 5;
  localparam int unsigned POS_Z_LSB = 10;
  localparam int unsigned FLUID_BIT = 15;
  localparam int unsigned OBS_BIT   = 16;
  localparam int unsigned STICK_BIT = 17;
  localparam int unsigned VX_LSB    = 18;
  localparam int unsigned VY_LSB    = 50;
  localparam int unsigned VZ_LSB    = 82;

  // Flag bits in the cell store
  localparam int unsigned F_FLUID = 0;
  localparam int unsigned F_OBS   = 1;
  localparam int unsigned F_STICK = 2;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_VEL  = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam logic [1:0] REG_MODE   = 2'd3;

  // Register reset values
  localparam logic [SIZE_W-1:0] SIZE_RST = 6'd32;
  localparam logic              MODE_RST = 1'b1;

  // Neighbor read order
  localparam int unsigned NUM_READS = 7;
  localparam logic [2:0] STEP_CTR  = 3'd0;
  localparam logic [2:0] STEP_XM   = 3'd1;
  localparam logic [2:0] STEP_XP   = 3'd2;
  localparam logic [2:0] STEP_YM   = 3'd3;
  localparam logic [2:0] STEP_YP   = 3'd4;
  localparam logic [2:0] STEP_ZM   = 3'd5;
  localparam logic [2:0] STEP_ZP   = 3'd6;

  typedef logic [FLAG_W-1:0] flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_DONE
  } mgwb_state_t;

endpackage

// ===== hdl/mgwb_ram.sv =====
module mgwb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/mac_grid_wall_boundary.sv =====
// Wall boundary rules on a staggered grid. Load items (in_tuser = 0) write one
// in-range cell's fluid/obstacle/stick marks into a single-port flag store and
// leave the sequencer idle. Velocity items (in_tuser = 1) read the flags of
// the cell and its six neighbors, one store read per cycle, then clear face
// words by the wall rules: an in-range velocity item reads in ST_READ, waits in
// ST_WAIT for the last data and loads the result in ST_DONE; an out-of-range one
// goes straight to ST_DONE. The result sits in an output register, so the
// next item is accepted while it waits. The store is never cleared: a cell must
// be loaded before a velocity item reads it or its neighbor flags.
module mac_grid_wall_boundary
  import mgwb_pkg::*;
#(
  parameter int unsigned MAX_X = MAX_X_DEF,
  parameter int unsigned MAX_Y = MAX_Y_DEF,
  parameter int unsigned MAX_Z = MAX_Z_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input item channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_x[4:0], pos_y[9:5], pos_z[14:10], is_fluid[15], is_obstacle[16],
  // is_stick[17], vel_x[49:18], vel_y[81:50], vel_z[113:82], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,   // kind[0]
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_vel_x[31:0], out_vel_y[63:32], out_vel_z[95:64]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,  // out_of_range[0]
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

`include "mac_grid_wall_boundary_defines.svh"

  localparam int unsigned DEPTH  = MAX_X * MAX_Y * MAX_Z;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] STRIDE_Y = ADDR_W'(MAX_X);
  localparam logic [ADDR_W-1:0] STRIDE_Z = ADDR_W'(MAX_X * MAX_Y);
  localparam logic [CMP_W-1:0]  CAP_X = CMP_W'(MAX_X);
  localparam logic [CMP_W-1:0]  CAP_Y = CMP_W'(MAX_Y);
  localparam logic [CMP_W-1:0]  CAP_Z = CMP_W'(MAX_Z);

  // ---------------- configuration registers ----------------
  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic              mode_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RST;
      size_y_r <= SIZE_RST;
      size_z_r <= SIZE_RST;
      mode_r   <= MODE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_SIZE_X: size_x_r <= cfg_pwdata[SIZE_W-1:0];
        REG_SIZE_Y: size_y_r <= cfg_pwdata[SIZE_W-1:0];
        REG_SIZE_Z: size_z_r <= cfg_pwdata[SIZE_W-1:0];
        REG_MODE:   mode_r   <= cfg_pwdata[0];
      endcase
    end
  end

  // register readback
  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[3:2])
      REG_SIZE_X: cfg_prdata = CFG_DW'(size_x_r);
      REG_SIZE_Y: cfg_prdata = CFG_DW'(size_y_r);
      REG_SIZE_Z: cfg_prdata = CFG_DW'(size_z_r);
      REG_MODE:   cfg_prdata = CFG_DW'(mode_r);
    endcase
  end

  // effective sizes, capped at the store capacity
  logic [CMP_W-1:0] sx, sy, sz;
  assign sx = (CMP_W'(size_x_r) < CAP_X) ? CMP_W'(size_x_r) : CAP_X;
  assign sy = (CMP_W'(size_y_r) < CAP_Y) ? CMP_W'(size_y_r) : CAP_Y;
  assign sz = (CMP_W'(size_z_r) < CAP_Z) ? CMP_W'(size_z_r) : CAP_Z;

  // ---------------- input field decode ----------------
  logic [POS_W-1:0] in_px, in_py, in_pz;
  logic             in_inr, in_acc;
  flags_t           in_flags;

  assign in_px    = in_tdata[POS_X_LSB +: POS_W];
  assign in_py    = in_tdata[POS_Y_LSB +: POS_W];
  assign in_pz    = in_tdata[POS_Z_LSB +: POS_W];
  assign in_flags = {in_tdata[STICK_BIT], in_tdata[OBS_BIT], in_tdata[FLUID_BIT]};
  assign in_inr   = (CMP_W'(in_px) < sx) && (CMP_W'(in_py) < sy) && (CMP_W'(in_pz) < sz);
  assign in_acc   = in_tvalid & in_tready;

  // ---------------- item registers ----------------
  logic [POS_W-1:0] px_r, py_r, pz_r;
  logic [VEL_W-1:0] vx_r, vy_r, vz_r;
  logic             inr_r, d3_r;
  logic             has_xm_r, has_xp_r, has_ym_r, has_yp_r, has_zm_r, has_zp_r;

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == KIND_VEL) begin
      px_r     <= in_px;
      py_r     <= in_py;
      pz_r     <= in_pz;
      vx_r     <= in_tdata[VX_LSB +: VEL_W];
      vy_r     <= in_tdata[VY_LSB +: VEL_W];
      vz_r     <= in_tdata[VZ_LSB +: VEL_W];
      inr_r    <= in_inr;
      d3_r     <= mode_r;
      has_xm_r <= in_px != '0;
      has_ym_r <= in_py != '0;
      has_zm_r <= in_pz != '0;
      has_xp_r <= (CMP_W'(in_px) + CMP_W'(1)) < sx;
      has_yp_r <= (CMP_W'(in_py) + CMP_W'(1)) < sy;
      has_zp_r <= (CMP_W'(in_pz) + CMP_W'(1)) < sz;
    end
  end

  // ---------------- sequencer ----------------
  mgwb_state_t state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        out_load;

  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == KIND_VEL) begin
          state_nxt = in_inr ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        if (step_r == STEP_ZP) begin
          step_nxt  = '0;
          state_nxt = ST_WAIT;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_WAIT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_tvalid || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // ---------------- store address ----------------
  logic [POS_W-1:0]  ax, ay, az;
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we;
  flags_t            ram_rdata;

  // neighbor coordinate for the current read; missing neighbors read the cell
  always_comb begin
    ax = px_r;
    ay = py_r;
    az = pz_r;
    if (state_r == ST_IDLE) begin
      ax = in_px;
      ay = in_py;
      az = in_pz;
    end else begin
      unique case (step_r)
        STEP_CTR: ;
        STEP_XM:  if (has_xm_r) ax = px_r - POS_W'(1);
        STEP_XP:  if (has_xp_r) ax = px_r + POS_W'(1);
        STEP_YM:  if (has_ym_r) ay = py_r - POS_W'(1);
        STEP_YP:  if (has_yp_r) ay = py_r + POS_W'(1);
        STEP_ZM:  if (has_zm_r) az = pz_r - POS_W'(1);
        STEP_ZP:  if (has_zp_r) az = pz_r + POS_W'(1);
        default:  ;
      endcase
    end
  end

  assign ram_addr = ADDR_W'(ax) + ADDR_W'(ay) * STRIDE_Y + ADDR_W'(az) * STRIDE_Z;
  assign ram_we   = in_acc && (in_tuser == KIND_LOAD) && in_inr;

  mgwb_ram #(
    .WIDTH (FLAG_W),
    .DEPTH (DEPTH)
  ) u_flag_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_flags),
    .rdata (ram_rdata)
  );

  // ---------------- read return capture ----------------
  logic       rd_vld_r;
  logic [2:0] rd_step_r;
  flags_t     nb_r [NUM_READS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_READ);
    end
  end

  always_ff @(posedge clk) begin
    rd_step_r <= step_r;
    if (rd_vld_r) begin
      nb_r[rd_step_r] <= ram_rdata;
    end
  end

  // ---------------- wall rules ----------------
  flags_t c_f, xm_f, xp_f, ym_f, yp_f, zm_f, zp_f;
  logic   fl, ob, act;
  logic   wall_x, wall_y, wall_z, stick_x, stick_y, stick_z;
  logic   clr_x, clr_y, clr_z;

  assign c_f  = nb_r[STEP_CTR];
  assign xm_f = nb_r[STEP_XM];
  assign xp_f = nb_r[STEP_XP];
  assign ym_f = nb_r[STEP_YM];
  assign yp_f = nb_r[STEP_YP];
  assign zm_f = nb_r[STEP_ZM];
  assign zp_f = nb_r[STEP_ZP];

  assign fl  = c_f[F_FLUID];
  assign ob  = c_f[F_OBS];
  assign act = inr_r && (fl || ob);

  // obstacle faces toward the lower neighbor
  assign wall_x = has_xm_r && (xm_f[F_OBS] || (ob && xm_f[F_FLUID]));
  assign wall_y = has_ym_r && (ym_f[F_OBS] || (ob && ym_f[F_FLUID]));
  assign wall_z = d3_r && has_zm_r && (zm_f[F_OBS] || (ob && zm_f[F_FLUID]));

  // stick walls on either side along each axis
  assign stick_x = (has_xm_r && xm_f[F_STICK]) || (has_xp_r && xp_f[F_STICK]);
  assign stick_y = (has_ym_r && ym_f[F_STICK]) || (has_yp_r && yp_f[F_STICK]);
  assign stick_z = d3_r && ((has_zm_r && zm_f[F_STICK]) || (has_zp_r && zp_f[F_STICK]));

  assign clr_x = act && (wall_x || (fl && (stick_y || stick_z)));
  assign clr_y = act && (wall_y || (fl && (stick_x || stick_z)));
  assign clr_z = act && (wall_z || (fl && d3_r && (stick_x || stick_y)));

  // ---------------- output register ----------------
  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {clr_z ? {VEL_W{1'b0}} : vz_r,
                     clr_y ? {VEL_W{1'b0}} : vy_r,
                     clr_x ? {VEL_W{1'b0}} : vx_r};
      out_oor_r  <= ~inr_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_oor_r;

  // ---------------- assertions ----------------
  `MGWB_ASSERT_NOW(a_we_idle, ram_we, state_r == ST_IDLE,
    "flag store written outside idle")
  `MGWB_ASSERT_NOW(a_step_idle, state_r != ST_READ, step_r == '0,
    "read step not parked outside read phase")
  `MGWB_ASSERT_NEXT(a_inr_reads, in_acc && in_tuser == KIND_VEL && in_inr,
    state_r == ST_READ, "in-range velocity item did not start reads")
  `MGWB_ASSERT_NEXT(a_oor_skip, in_acc && in_tuser == KIND_VEL && !in_inr,
    state_r == ST_DONE, "out-of-range velocity item did not skip reads")
  `MGWB_ASSERT_NOW(a_out_src, $rose(out_tvalid), $past(state_r) == ST_DONE,
    "result presented without finishing an item")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import mgwb_pkg::*;

  localparam int GRID        = 32;       // store capacity per axis at default parameters
  localparam int BLOCK       = 6;        // corner block loaded up front, 0..BLOCK-1 per axis
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 20;       // cycles after the last result before a register write
  localparam int HOLD_CYCLES = 600;

  localparam flags_t FL_FLUID = flags_t'(1 << F_FLUID);
  localparam flags_t FL_OBS   = flags_t'(1 << F_OBS);
  localparam flags_t FL_STICK = flags_t'(1 << F_STICK);

  typedef struct {
    logic             kind;
    logic [POS_W-1:0] px, py, pz;
    logic             fl, ob, st;
    logic [VEL_W-1:0] vx, vy, vz;
  } grid_item_t;

  typedef struct {
    logic [VEL_W-1:0] vx, vy, vz;
    logic             oor;
  } wall_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  mac_grid_wall_boundary uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: flag store and register copies
  flags_t            class_mem [GRID*GRID*GRID];
  logic [SIZE_W-1:0] cur_sx = SIZE_RST;
  logic [SIZE_W-1:0] cur_sy = SIZE_RST;
  logic [SIZE_W-1:0] cur_sz = SIZE_RST;
  logic              cur_3d = MODE_RST;

  // Stimulus side: cells known to hold marks, pending items, expected results
  bit           gen_loaded [GRID*GRID*GRID];
  grid_item_t   pending_items [$];
  wall_result_t wall_expect_q [$];
  int           gen_count = 0;

  grid_item_t   cur_item;
  wall_result_t exp_r;
  logic         in_acc = 1'b0;
  logic [CFG_DW-1:0] cfg_rd_cap;
  int  err_cnt = 0;
  int  results_seen = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  bit  burst_mode = 0;

  function automatic int eff_size(logic [SIZE_W-1:0] r);
    return (r > GRID) ? GRID : int'(r);
  endfunction

  function automatic bit in_grid(int x, int y, int z);
    return x < eff_size(cur_sx) && y < eff_size(cur_sy) && z < eff_size(cur_sz);
  endfunction

  function automatic int cell_idx(int x, int y, int z);
    return x + GRID * (y + GRID * z);
  endfunction

  function automatic flags_t cell_flags(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= GRID || y >= GRID || z >= GRID) return '0;
    return class_mem[cell_idx(x, y, z)];
  endfunction

  function automatic bit stick_at(int x, int y, int z);
    flags_t f;
    f = cell_flags(x, y, z);
    return f[F_STICK];
  endfunction

  // Store update or wall rules for one accepted item
  task automatic predict_item(grid_item_t it);
    int i, j, k, sx, sy, sz;
    flags_t c, n;
    bit fl, ob, d3;
    wall_result_t r;
    i = int'(it.px);
    j = int'(it.py);
    k = int'(it.pz);
    sx = eff_size(cur_sx);
    sy = eff_size(cur_sy);
    sz = eff_size(cur_sz);
    if (it.kind == KIND_LOAD) begin
      if (in_grid(i, j, k)) class_mem[cell_idx(i, j, k)] = {it.st, it.ob, it.fl};
      return;
    end
    r.vx = it.vx;
    r.vy = it.vy;
    r.vz = it.vz;
    r.oor = !in_grid(i, j, k);
    if (!r.oor) begin
      c = cell_flags(i, j, k);
      fl = c[F_FLUID];
      ob = c[F_OBS];
      d3 = cur_3d;
      if (fl || ob) begin
        // faces shared with an obstacle, or obstacle over fluid below
        if (i > 0) begin
          n = cell_flags(i - 1, j, k);
          if (n[F_OBS] || (ob && n[F_FLUID])) r.vx = '0;
        end
        if (j > 0) begin
          n = cell_flags(i, j - 1, k);
          if (n[F_OBS] || (ob && n[F_FLUID])) r.vy = '0;
        end
        if (d3 && k > 0) begin
          n = cell_flags(i, j, k - 1);
          if (n[F_OBS] || (ob && n[F_FLUID])) r.vz = '0;
        end
        // no-slip: tangential components next to stick walls
        if (fl) begin
          if ((i > 0 && stick_at(i - 1, j, k)) || (i + 1 < sx && stick_at(i + 1, j, k))) begin
            r.vy = '0;
            if (d3) r.vz = '0;
          end
          if ((j > 0 && stick_at(i, j - 1, k)) || (j + 1 < sy && stick_at(i, j + 1, k))) begin
            r.vx = '0;
            if (d3) r.vz = '0;
          end
          if (d3 && ((k > 0 && stick_at(i, j, k - 1)) ||
                     (k + 1 < sz && stick_at(i, j, k + 1)))) begin
            r.vx = '0;
            r.vy = '0;
          end
        end
      end
    end
    wall_expect_q.push_back(r);
  endtask

  function automatic logic [IN_DATA_W-1:0] pack_item(grid_item_t it);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[POS_X_LSB +: POS_W] = it.px;
    d[POS_Y_LSB +: POS_W] = it.py;
    d[POS_Z_LSB +: POS_W] = it.pz;
    d[FLUID_BIT] = it.fl;
    d[OBS_BIT] = it.ob;
    d[STICK_BIT] = it.st;
    d[VX_LSB +: VEL_W] = it.vx;
    d[VY_LSB +: VEL_W] = it.vy;
    d[VZ_LSB +: VEL_W] = it.vz;
    return d;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_item(grid_item_t it);
    pending_items.push_back(it);
    gen_count++;
    if (it.kind == KIND_LOAD && in_grid(int'(it.px), int'(it.py), int'(it.pz)))
      gen_loaded[cell_idx(int'(it.px), int'(it.py), int'(it.pz))] = 1;
  endtask

  task automatic add_load(int x, int y, int z, flags_t f);
    grid_item_t it;
    it.kind = KIND_LOAD;
    it.px = POS_W'(x);
    it.py = POS_W'(y);
    it.pz = POS_W'(z);
    it.fl = f[F_FLUID];
    it.ob = f[F_OBS];
    it.st = f[F_STICK];
    it.vx = $urandom;
    it.vy = $urandom;
    it.vz = $urandom;
    push_item(it);
  endtask

  task automatic add_vel(int x, int y, int z, logic [VEL_W-1:0] a, logic [VEL_W-1:0] b,
                         logic [VEL_W-1:0] c);
    grid_item_t it;
    it.kind = KIND_VEL;
    it.px = POS_W'(x);
    it.py = POS_W'(y);
    it.pz = POS_W'(z);
    {it.st, it.ob, it.fl} = FLAG_W'($urandom_range(0, 7));
    it.vx = a;
    it.vy = b;
    it.vz = c;
    push_item(it);
  endtask

  // Load the cell and its neighbors (fresh marks where asked, or where never
  // loaded), then send the velocity item. Fails if an unloaded neighbor cannot
  // be loaded under the current sizes.
  task automatic add_cell_seq(int x, int y, int z, bit reload, output bit ok);
    int dx [7] = '{0, -1, 1, 0, 0, 0, 0};
    int dy [7] = '{0, 0, 0, -1, 1, 0, 0};
    int dz [7] = '{0, 0, 0, 0, 0, -1, 1};
    int nx, ny, nz;
    ok = 1;
    for (int d = 0; d < 7; d++) begin
      nx = x + dx[d];
      ny = y + dy[d];
      nz = z + dz[d];
      if (nx < 0 || ny < 0 || nz < 0 || nx >= GRID || ny >= GRID || nz >= GRID) continue;
      if (!gen_loaded[cell_idx(nx, ny, nz)] && !in_grid(nx, ny, nz)) ok = 0;
    end
    if (!ok) return;
    for (int d = 0; d < 7; d++) begin
      nx = x + dx[d];
      ny = y + dy[d];
      nz = z + dz[d];
      if (nx < 0 || ny < 0 || nz < 0 || nx >= GRID || ny >= GRID || nz >= GRID) continue;
      if (in_grid(nx, ny, nz) && (reload || !gen_loaded[cell_idx(nx, ny, nz)]))
        add_load(nx, ny, nz, flags_t'($urandom_range(0, 7)));
    end
    add_vel(x, y, z, $urandom, $urandom, $urandom);
  endtask

  // Random stimulus: mostly load-then-read sequences, plus stray loads and
  // out-of-range velocity items
  task automatic add_random(int budget);
    int stop, r, x, y, z, ex, ey, ez;
    bit ok;
    stop = gen_count + budget;
    ex = eff_size(cur_sx);
    ey = eff_size(cur_sy);
    ez = eff_size(cur_sz);
    while (gen_count < stop) begin
      r = $urandom_range(0, 99);
      if (r < 70 && ex > 0 && ey > 0 && ez > 0) begin
        x = $urandom_range(0, ex - 1);
        y = $urandom_range(0, ey - 1);
        z = $urandom_range(0, ez - 1);
        add_cell_seq(x, y, z, $urandom_range(0, 9) < 7, ok);
        if (!ok) begin
          // fall back into the preloaded corner
          x = $urandom_range(0, ((ex < BLOCK - 1) ? ex : BLOCK - 1) - 1);
          y = $urandom_range(0, ((ey < BLOCK - 1) ? ey : BLOCK - 1) - 1);
          z = $urandom_range(0, ((ez < BLOCK - 1) ? ez : BLOCK - 1) - 1);
          add_cell_seq(x, y, z, 1'($urandom_range(0, 1)), ok);
        end
      end else if (r < 85 || (ex == GRID && ey == GRID && ez == GRID)) begin
        add_load($urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                 $urandom_range(0, GRID - 1), flags_t'($urandom_range(0, 7)));
      end else begin
        x = $urandom_range(0, GRID - 1);
        y = $urandom_range(0, GRID - 1);
        z = $urandom_range(0, GRID - 1);
        if (in_grid(x, y, z)) begin
          if (ex < GRID) x = $urandom_range(ex, GRID - 1);
          else if (ey < GRID) y = $urandom_range(ey, GRID - 1);
          else z = $urandom_range(ez, GRID - 1);
        end
        add_vel(x, y, z, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || wall_expect_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic reg_check(logic [1:0] idx, logic [CFG_DW-1:0] expv);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = {idx, 2'b00};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    if (cfg_rd_cap !== expv) begin
      $error("cfg_prdata reg %0d: expected %0h, actual %0h", idx, expv, cfg_rd_cap);
      err_cnt++;
    end
  endtask

  task automatic reg_write(logic [1:0] idx, logic [CFG_DW-1:0] v);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    case (idx)
      REG_SIZE_X: cur_sx = v[SIZE_W-1:0];
      REG_SIZE_Y: cur_sy = v[SIZE_W-1:0];
      REG_SIZE_Z: cur_sz = v[SIZE_W-1:0];
      default:    cur_3d = v[0];
    endcase
    reg_check(idx, (idx == REG_MODE) ? CFG_DW'(v[0]) : CFG_DW'(v[SIZE_W-1:0]));
  endtask

  // Input driver
  always @(negedge clk) begin
    if (!in_tvalid || in_acc) begin
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap--;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        in_tdata <= pack_item(cur_item);
        in_tuser <= cur_item.kind;
        in_tvalid <= 1'b1;
        send_gap = burst_mode ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver; one long hold-off early on to back the block up
  always @(negedge clk) begin
    if (!hold_done && results_seen >= 20) begin
      hold_done = 1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (recv_gap > 0) begin
      out_tready <= 1'b0;
      recv_gap--;
    end else begin
      out_tready <= 1'b1;
      recv_gap = burst_mode ? 0 : pick_gap();
    end
  end

  // Monitor: check results, predict on accepted items
  always @(posedge clk) begin
    in_acc <= in_tvalid && in_tready;
    if (cfg_psel && cfg_penable && !cfg_pwrite) cfg_rd_cap <= cfg_prdata;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (wall_expect_q.size() == 0) begin
        $error("unexpected result: out_tdata %h out_tuser %b", out_tdata, out_tuser);
        err_cnt++;
      end else begin
        exp_r = wall_expect_q.pop_front();
        if (out_tdata[0 +: VEL_W] !== exp_r.vx) begin
          $error("out_vel_x: expected %h, actual %h", exp_r.vx, out_tdata[0 +: VEL_W]);
          err_cnt++;
        end
        if (out_tdata[VEL_W +: VEL_W] !== exp_r.vy) begin
          $error("out_vel_y: expected %h, actual %h", exp_r.vy, out_tdata[VEL_W +: VEL_W]);
          err_cnt++;
        end
        if (out_tdata[2*VEL_W +: VEL_W] !== exp_r.vz) begin
          $error("out_vel_z: expected %h, actual %h", exp_r.vz, out_tdata[2*VEL_W +: VEL_W]);
          err_cnt++;
        end
        if (out_tuser !== exp_r.oor) begin
          $error("out_of_range: expected %b, actual %b", exp_r.oor, out_tuser);
          err_cnt++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) predict_item(cur_item);
  end

  // Run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb failed");
    $finish;
  end

  initial begin
    int phase_cfg [7][4] = '{'{5, 4, 3, 1}, '{1, 1, 1, 1}, '{32, 32, 32, 0}, '{0, 7, 3, 1},
                             '{63, 2, 5, 0}, '{3, 32, 1, 1}, '{32, 32, 32, 1}};
    int phase_len [7] = '{150, 60, 200, 40, 150, 150, 150};
    bit ok;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values
    reg_check(REG_SIZE_X, CFG_DW'(SIZE_RST));
    reg_check(REG_SIZE_Y, CFG_DW'(SIZE_RST));
    reg_check(REG_SIZE_Z, CFG_DW'(SIZE_RST));
    reg_check(REG_MODE, CFG_DW'(MODE_RST));

    // preload the corner block so small grids always have marked neighbors
    for (int z = 0; z < BLOCK; z++)
      for (int y = 0; y < BLOCK; y++)
        for (int x = 0; x < BLOCK; x++)
          add_load(x, y, z, flags_t'($urandom_range(0, 7)));

    // directed: corners, word extremes, each wall rule
    add_vel(0, 0, 0, '1, '1, '1);
    add_vel(4, 4, 4, '0, '0, '0);
    add_load(1, 1, 1, FL_FLUID);
    add_load(0, 1, 1, FL_OBS);
    add_load(1, 0, 1, FL_STICK);
    add_load(2, 1, 1, FL_STICK);
    add_load(1, 2, 1, FL_FLUID);
    add_load(1, 1, 0, FL_OBS);
    add_load(1, 1, 2, FL_STICK);
    add_vel(1, 1, 1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
    // obstacle over fluid on every axis
    add_load(3, 3, 3, FL_OBS);
    add_load(2, 3, 3, FL_FLUID);
    add_load(3, 2, 3, FL_FLUID);
    add_load(3, 3, 2, FL_FLUID);
    add_vel(3, 3, 3, 32'h1234_5678, 32'h8000_0001, 32'h7FFF_FFFE);
    // stick-only cell passes through
    add_load(2, 2, 2, FL_STICK);
    add_vel(2, 2, 2, $urandom, $urandom, $urandom);
    add_cell_seq(GRID - 1, GRID - 1, GRID - 1, 1'b1, ok);
    add_random(250);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      burst_mode = (p == 2);
      reg_write(REG_SIZE_X, phase_cfg[p][0]);
      reg_write(REG_SIZE_Y, phase_cfg[p][1]);
      reg_write(REG_SIZE_Z, phase_cfg[p][2]);
      reg_write(REG_MODE, phase_cfg[p][3]);
      if (p == 0) begin
        // out-of-range load is dropped, out-of-range velocity passes through
        add_load(GRID - 1, 0, 0, FL_STICK);
        add_vel(5, 0, 0, '1, '1, '1);
        add_vel(0, 0, GRID - 1, $urandom, $urandom, $urandom);
      end
      add_random(phase_len[p]);
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
